// ===== src/dlaq_pkg.sv =====
// Package with shared constants and codes for the delta-list alarm queue.
`timescale 1ns / 1ps

package dlaq_pkg;

  localparam int QueueDepth = 16;
  localparam int TimeBits   = 32;
  localparam int MaxResults = 16;

  localparam int DelayWidth = 32;
  localparam int TagWidth   = 8;
  localparam int KindWidth  = 2;
  localparam int InDataWidth = 2 * DelayWidth + TagWidth;

  typedef enum logic {
    REQ_ADD  = 1'b0,
    REQ_TICK = 1'b1
  } req_kind_t;

  typedef enum logic [KindWidth-1:0] {
    EV_ADDED    = 2'd0,
    EV_REJECTED = 2'd1,
    EV_FIRED    = 2'd2
  } event_kind_t;

endpackage

// ===== src/delta_list_alarm_queue_core.sv =====
// Delta-list alarm queue: many alarms sharing one countdown, stored by relative expiry.
`timescale 1ns / 1ps

// The queue holds up to QUEUE_DEPTH alarms sorted by expiry, each storing its delay
// relative to the alarm before it, so a tick only decrements the head. An add word
// (tuser 0) yields one word back: alarm added, or rejected when the queue is full.
// An accepted add walks the p entries before the insert point (at most the number of
// live entries) and then inserts, because one subtractor compares and subtracts one
// stored delta per cycle; a rejected add goes straight to its result word.
// A tick word (tuser 1) yields one fired word per expiring alarm, up to MaxResults,
// with tlast on the final one and nothing on an empty queue or when nothing expires.
// A tick that fires nothing decrements the head and returns to idle; each firing pops
// the head, and a fired alarm that reloads is walked back in. Each result word also waits
// while the previous one still sits unaccepted in the output register. The block
// accepts a new word only between requests; a result left in the output register does
// not stop the next word from being accepted.
module delta_list_alarm_queue_core #(
  parameter int QUEUE_DEPTH = dlaq_pkg::QueueDepth,
  parameter int TIME_BITS   = dlaq_pkg::TimeBits
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // first_delay [31:0], reload_interval [63:32], alarm_tag [71:64]
  input  logic [dlaq_pkg::InDataWidth-1:0]     s_tdata,
  // req_type
  input  logic                                 s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // fired_tag
  output logic [dlaq_pkg::TagWidth-1:0]        m_tdata,
  // event_kind
  output logic [dlaq_pkg::KindWidth-1:0]       m_tuser,
  // last_of_run
  output logic                                 m_tlast
);

  localparam int PosW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int NumW = $clog2(dlaq_pkg::MaxResults + 1);
  localparam int DW   = dlaq_pkg::DelayWidth;
  localparam int TW   = dlaq_pkg::TagWidth;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_FIRE,
    ST_WALK,
    ST_INSERT,
    ST_EMIT
  } state_t;

  state_t                 state;
  logic [CntW-1:0]        count;
  logic [PosW-1:0]        pos;
  logic [TIME_BITS-1:0]   rem;
  logic [TIME_BITS-1:0]   ins_reload;
  logic [TW-1:0]          ins_tag;
  logic                   is_tick;
  logic                   more;
  logic [NumW-1:0]        nfired;
  dlaq_pkg::event_kind_t  emit_kind;

  logic [TIME_BITS-1:0]   entry_delta  [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]   entry_reload [QUEUE_DEPTH];
  logic [TW-1:0]          entry_tag    [QUEUE_DEPTH];

  logic [DW-1:0]          in_delay;
  logic [DW-1:0]          in_reload;
  logic [TW-1:0]          in_tag;
  logic [TIME_BITS-1:0]   delay_sat;
  logic [TIME_BITS-1:0]   delay_c;
  logic [TIME_BITS-1:0]   reload_c;

  logic [TIME_BITS-1:0]   rd_delta;
  logic [TIME_BITS-1:0]   sub_a;
  logic [TIME_BITS-1:0]   sub_b;
  logic [TIME_BITS:0]     sub_res;
  logic                   borrow;
  logic [TIME_BITS-1:0]   diff;
  logic                   out_free;
  logic                   load_out;
  logic                   more_now;
  logic                   accept;

  assign in_delay  = s_tdata[DW-1:0];
  assign in_reload = s_tdata[2*DW-1:DW];
  assign in_tag    = s_tdata[2*DW+TW-1:2*DW];

  generate
    if (TIME_BITS >= DW) begin : g_wide
      assign delay_sat = TIME_BITS'(in_delay);
      assign reload_c  = TIME_BITS'(in_reload);
    end else begin : g_narrow
      assign delay_sat = (|in_delay[DW-1:TIME_BITS]) ? '1 : in_delay[TIME_BITS-1:0];
      assign reload_c  = (|in_reload[DW-1:TIME_BITS]) ? '1 : in_reload[TIME_BITS-1:0];
    end
  endgenerate

  assign delay_c = (delay_sat == '0) ? TIME_BITS'(1) : delay_sat;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign load_out = out_free &&
                    ((state == ST_FIRE && entry_delta[0] == '0) || state == ST_EMIT);
  assign rd_delta = entry_delta[pos];

  // Shared subtractor: tick decrement, list walk and successor fix-up.
  always_comb begin
    unique case (state)
      ST_DEC: begin
        sub_a = entry_delta[0];
        sub_b = TIME_BITS'(1);
      end
      ST_INSERT: begin
        sub_a = rd_delta;
        sub_b = rem;
      end
      default: begin
        sub_a = rem;
        sub_b = rd_delta;
      end
    endcase
  end

  assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow  = sub_res[TIME_BITS];
  assign diff    = sub_res[TIME_BITS-1:0];

  assign more_now = (count > CntW'(1)) && (entry_delta[1] == '0) &&
                    ((nfired + NumW'(1)) < NumW'(dlaq_pkg::MaxResults));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      nfired   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            rem        <= delay_c;
            ins_reload <= reload_c;
            ins_tag    <= in_tag;
            pos        <= '0;
            nfired     <= '0;
            more       <= 1'b0;
            if (s_tuser == dlaq_pkg::REQ_TICK) begin
              is_tick <= 1'b1;
              if (count != '0) begin
                state <= ST_DEC;
              end
            end else begin
              is_tick <= 1'b0;
              if (count == CntW'(QUEUE_DEPTH)) begin
                emit_kind <= dlaq_pkg::EV_REJECTED;
                state     <= ST_EMIT;
              end else begin
                state <= ST_WALK;
              end
            end
          end
        end
        ST_DEC: begin
          if (entry_delta[0] != '0) begin
            entry_delta[0] <= diff;
          end
          state <= ST_FIRE;
        end
        ST_FIRE: begin
          if (entry_delta[0] != '0) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            m_tuser  <= dlaq_pkg::EV_FIRED;
            m_tdata  <= entry_tag[0];
            m_tlast  <= !more_now;
            for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
              entry_delta[k]  <= entry_delta[k+1];
              entry_reload[k] <= entry_reload[k+1];
              entry_tag[k]    <= entry_tag[k+1];
            end
            count  <= count - CntW'(1);
            nfired <= nfired + NumW'(1);
            more   <= more_now;
            if (entry_reload[0] != '0) begin
              rem        <= entry_reload[0];
              ins_reload <= entry_reload[0];
              ins_tag    <= entry_tag[0];
              pos        <= '0;
              state      <= ST_WALK;
            end else if (!more_now) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_WALK: begin
          if (CntW'(pos) == count || borrow) begin
            state <= ST_INSERT;
          end else begin
            rem <= diff;
            pos <= pos + PosW'(1);
          end
        end
        ST_INSERT: begin
          for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (PosW'(k) == pos) begin
              entry_delta[k]  <= rem;
              entry_reload[k] <= ins_reload;
              entry_tag[k]    <= ins_tag;
            end else if (k > 0 && PosW'(k) > pos && CntW'(k) <= count) begin
              entry_delta[k]  <= (PosW'(k - 1) == pos) ? diff : entry_delta[k-1];
              entry_reload[k] <= entry_reload[k-1];
              entry_tag[k]    <= entry_tag[k-1];
            end
          end
          count <= count + CntW'(1);
          if (is_tick) begin
            state <= more ? ST_FIRE : ST_IDLE;
          end else begin
            emit_kind <= dlaq_pkg::EV_ADDED;
            state     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tuser  <= emit_kind;
            m_tdata  <= ins_tag;
            m_tlast  <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count) || count == $past(count) + CntW'(1) ||
                     count == $past(count) - CntW'(1)))
    else $error("entry count moved by more than one");

  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == dlaq_pkg::REQ_ADD && count == CntW'(QUEUE_DEPTH)) |=>
      (state == ST_EMIT && emit_kind == dlaq_pkg::EV_REJECTED))
    else $error("add on a full queue was not rejected");

  a_fire_limit: assert property (@(posedge clk) disable iff (rst)
    nfired <= NumW'(dlaq_pkg::MaxResults))
    else $error("too many alarms fired on one tick");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the delta-list alarm queue core.
`timescale 1ns / 1ps

module tb_top;

  localparam int RandomItems = 134;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 400;
  localparam int CycleLimit  = 600000;

  typedef struct packed {
    dlaq_pkg::event_kind_t         kind;
    logic [dlaq_pkg::TagWidth-1:0] tag;
    logic                          last;
  } alarm_event_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [dlaq_pkg::InDataWidth-1:0] s_tdata = '0;
  logic                             s_tuser = 1'b0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [dlaq_pkg::TagWidth-1:0]    m_tdata;
  logic [dlaq_pkg::KindWidth-1:0]   m_tuser;
  logic                             m_tlast;

  // Shadow copy of the alarm list, kept in step with accepted requests.
  logic [dlaq_pkg::TimeBits-1:0] shadow_delta [dlaq_pkg::QueueDepth];
  logic [dlaq_pkg::TimeBits-1:0] shadow_reload[dlaq_pkg::QueueDepth];
  logic [dlaq_pkg::TagWidth-1:0] shadow_tag   [dlaq_pkg::QueueDepth];
  int unsigned                   shadow_count = 0;

  alarm_event_t pending_events[$];
  alarm_event_t want_event;

  int  errors = 0;
  int  cycle_count = 0;
  int  hold_requests = 0;
  bit  idle_enabled = 1'b1;
  int  adds_sent = 0;
  int  ticks_sent = 0;
  int  seen_added = 0;
  int  seen_rejected = 0;
  int  seen_fired = 0;

  delta_list_alarm_queue_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("delta_list_alarm_queue_core: mismatch");
      $finish;
    end
  end

  // Time is as wide as the input fields here, so no saturation is needed.
  function automatic void list_insert(logic [dlaq_pkg::TimeBits-1:0] delay,
                                      logic [dlaq_pkg::TimeBits-1:0] reload,
                                      logic [dlaq_pkg::TagWidth-1:0] tag);
    logic [dlaq_pkg::TimeBits-1:0] rest;
    int unsigned pos;
    int unsigned k;
    rest = delay;
    pos = 0;
    while (pos < shadow_count && shadow_delta[pos] <= rest) begin
      rest -= shadow_delta[pos];
      pos++;
    end
    for (k = shadow_count; k > pos; k--) begin
      shadow_delta[k]  = shadow_delta[k-1];
      shadow_reload[k] = shadow_reload[k-1];
      shadow_tag[k]    = shadow_tag[k-1];
    end
    shadow_delta[pos]  = rest;
    shadow_reload[pos] = reload;
    shadow_tag[pos]    = tag;
    shadow_count++;
    if (pos + 1 < shadow_count) shadow_delta[pos+1] -= rest;
  endfunction

  function automatic void predict_request(dlaq_pkg::req_kind_t kind,
                                          logic [dlaq_pkg::DelayWidth-1:0] delay,
                                          logic [dlaq_pkg::DelayWidth-1:0] reload,
                                          logic [dlaq_pkg::TagWidth-1:0] tag);
    alarm_event_t ev;
    logic [dlaq_pkg::TimeBits-1:0] head_reload;
    int n;
    int unsigned k;
    n = 0;
    if (kind == dlaq_pkg::REQ_ADD) begin
      if (delay == '0) delay = 1;
      ev.tag = tag;
      ev.last = 1'b1;
      if (shadow_count >= dlaq_pkg::QueueDepth) begin
        ev.kind = dlaq_pkg::EV_REJECTED;
      end else begin
        list_insert(delay, reload, tag);
        ev.kind = dlaq_pkg::EV_ADDED;
      end
      pending_events.push_back(ev);
    end else if (shadow_count != 0) begin
      if (shadow_delta[0] != '0) shadow_delta[0] -= 1;
      while (shadow_count > 0 && shadow_delta[0] == '0 && n < dlaq_pkg::MaxResults) begin
        head_reload = shadow_reload[0];
        ev.kind = dlaq_pkg::EV_FIRED;
        ev.tag = shadow_tag[0];
        ev.last = 1'b0;
        for (k = 0; k + 1 < shadow_count; k++) begin
          shadow_delta[k]  = shadow_delta[k+1];
          shadow_reload[k] = shadow_reload[k+1];
          shadow_tag[k]    = shadow_tag[k+1];
        end
        shadow_count--;
        pending_events.push_back(ev);
        n++;
        if (head_reload != '0) list_insert(head_reload, head_reload, ev.tag);
      end
      if (n > 0) pending_events[pending_events.size()-1].last = 1'b1;
    end
  endfunction

  task automatic send_request(dlaq_pkg::req_kind_t kind,
                              logic [dlaq_pkg::DelayWidth-1:0] delay,
                              logic [dlaq_pkg::DelayWidth-1:0] reload,
                              logic [dlaq_pkg::TagWidth-1:0] tag);
    while (idle_enabled && $urandom_range(99) < 21) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {tag, reload, delay};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_request(kind, delay, reload, tag);
    if (kind == dlaq_pkg::REQ_ADD) adds_sent++;
    else ticks_sent++;
  endtask

  function automatic logic [dlaq_pkg::DelayWidth-1:0] pick_reload();
    int roll;
    roll = $urandom_range(99);
    if (roll < 88) return '0;
    if (roll < 97) return $urandom_range(1, 12);
    return $urandom;
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected word kind=%0d tag=%0h last=%0b",
                 $time, m_tuser, m_tdata, m_tlast);
        errors++;
      end else begin
        want_event = pending_events.pop_front();
        if (m_tuser !== want_event.kind) begin
          $display("%0t: event_kind expected %0d actual %0d", $time, want_event.kind, m_tuser);
          errors++;
        end
        if (m_tdata !== want_event.tag) begin
          $display("%0t: fired_tag expected %0h actual %0h", $time, want_event.tag, m_tdata);
          errors++;
        end
        if (m_tlast !== want_event.last) begin
          $display("%0t: last_of_run expected %0b actual %0b", $time, want_event.last, m_tlast);
          errors++;
        end
        unique case (m_tuser)
          dlaq_pkg::EV_ADDED:    seen_added++;
          dlaq_pkg::EV_REJECTED: seen_rejected++;
          default:               seen_fired++;
        endcase
      end
    end
  end

  // Result receiver; a hold-off request keeps it stalled for a long stretch.
  initial begin
    int served;
    int i;
    served = 0;
    forever begin
      @(posedge clk);
      if (served != hold_requests) begin
        served = hold_requests;
        for (i = 0; i < HoldCycles; i++) begin
          m_tready <= 1'b0;
          @(posedge clk);
        end
        m_tready <= 1'b1;
      end else begin
        m_tready <= !(idle_enabled && $urandom_range(99) < 21);
      end
    end
  end

  task automatic test_empty_tick();
    send_request(dlaq_pkg::REQ_TICK, $urandom, $urandom, 8'($urandom_range(255)));
  endtask

  task automatic test_full_queue();
    int i;
    for (i = 0; i < dlaq_pkg::QueueDepth; i++)
      send_request(dlaq_pkg::REQ_ADD, 1, 0, 8'(i + 16));
    send_request(dlaq_pkg::REQ_ADD, '1, '1, 8'hFF);
    send_request(dlaq_pkg::REQ_ADD, '0, '0, 8'h00);
    send_request(dlaq_pkg::REQ_TICK, '0, '0, 8'h00);
  endtask

  task automatic test_insert_order();
    send_request(dlaq_pkg::REQ_ADD, 0, 0, 8'h01);
    send_request(dlaq_pkg::REQ_ADD, 1, 0, 8'h02);
    send_request(dlaq_pkg::REQ_ADD, 3, 0, 8'h03);
    send_request(dlaq_pkg::REQ_ADD, 6, 0, 8'h04);
    send_request(dlaq_pkg::REQ_ADD, 4, 0, 8'h05);
    repeat (6) send_request(dlaq_pkg::REQ_TICK, '1, '1, 8'hFF);
  endtask

  task automatic test_reload();
    send_request(dlaq_pkg::REQ_ADD, 1, 2, 8'hA5);
    repeat (3)
      send_request(dlaq_pkg::REQ_TICK, $urandom, $urandom, 8'($urandom_range(255)));
    send_request(dlaq_pkg::REQ_ADD, '1, '1, 8'h5A);
  endtask

  task automatic test_random_traffic();
    int sent;
    int n;
    int roll;
    logic [dlaq_pkg::DelayWidth-1:0] base;
    logic [dlaq_pkg::DelayWidth-1:0] delay;
    sent = 0;
    while (sent < RandomItems) begin
      idle_enabled = !(sent >= 50 && sent < 100);
      if ($urandom_range(99) < 65) begin
        n = $urandom_range(1, 5);
        base = $urandom_range(1, 6);
        repeat (n) begin
          delay = ($urandom_range(1) == 0) ? base : base + $urandom_range(0, 3);
          send_request(dlaq_pkg::REQ_ADD, delay, pick_reload(), 8'($urandom_range(255)));
          sent++;
        end
        repeat ($urandom_range(1, 8)) begin
          send_request(dlaq_pkg::REQ_TICK, $urandom, $urandom, 8'($urandom_range(255)));
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          roll = $urandom_range(99);
          if (roll < 50) begin
            send_request(dlaq_pkg::REQ_TICK, $urandom, $urandom, 8'($urandom_range(255)));
          end else begin
            if (roll < 70) delay = $urandom_range(0, 20);
            else if (roll < 92) delay = $urandom_range(0, 300);
            else delay = $urandom;
            send_request(dlaq_pkg::REQ_ADD, delay, pick_reload(), 8'($urandom_range(255)));
          end
          sent++;
        end
      end
    end
    idle_enabled = 1'b1;
  endtask

  task automatic test_backpressure();
    hold_requests <= hold_requests + 1;
    repeat (40) begin
      if ($urandom_range(99) < 60)
        send_request(dlaq_pkg::REQ_ADD, $urandom_range(1, 4), 0, 8'($urandom_range(255)));
      else
        send_request(dlaq_pkg::REQ_TICK, $urandom, $urandom, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_tick();
    test_full_queue();
    test_insert_order();
    test_reload();
    test_random_traffic();
    test_backpressure();
    s_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (pending_events.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, pending_events.size());
      errors++;
    end
    $display("Covered %0d add and %0d tick requests, with a full queue and a long output stall.",
             adds_sent, ticks_sent);
    $display("Checked %0d added, %0d rejected and %0d fired words; %0d errors.",
             seen_added, seen_rejected, seen_fired, errors);
    if (errors == 0) begin
      $display("delta_list_alarm_queue_core: match");
    end else begin
      $display("delta_list_alarm_queue_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/dlaq_pkg.sv
src/delta_list_alarm_queue_core.sv
bench/tb_top.sv
